[rtl/ofpl_pkg.sv]
// ---------------------------------------------------------------------------
// ofpl_pkg: shared constants for the output fault protection lock
// Item mode codes, configuration register indexes, field widths and the
// reset values of the hold times.
// ---------------------------------------------------------------------------
package ofpl_pkg;

    localparam int FIELD_W = 8;
    localparam int AGE_W   = 16;
    localparam int CFG_W   = 16;

    localparam logic [2:0] MODE_TICK      = 3'd0;
    localparam logic [2:0] MODE_OV        = 3'd1;
    localparam logic [2:0] MODE_THERMAL   = 3'd2;
    localparam logic [2:0] MODE_DRIVE_WR  = 3'd3;
    localparam logic [2:0] MODE_PP_WR     = 3'd4;

    localparam logic [1:0] CFG_OV_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_OV_HOLD    = 2'd1;
    localparam logic [1:0] CFG_TH_HOLD    = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] OV_HOLD_RESET = 16'd10000;
    localparam logic [AGE_W-1:0] TH_HOLD_RESET = 16'd30000;

endpackage

[rtl/output_fault_protection_lock.sv]
// ---------------------------------------------------------------------------
// output_fault_protection_lock: over-voltage and thermal lock controller
// Usage:
//   Input channel (in_valid / in_stall) carries one item: mode, status_bits,
//   pin_index, pin_value. A transfer happens on a rising edge with in_valid
//   high and in_stall low. Every item yields exactly one result on the
//   output channel (out_valid / out_stall): drive, push-pull and lock bits
//   after the item, plus the accepted flag for user writes.
//   The result is registered and valid the cycle after the input transfer.
//   Throughput: one item per cycle while in_stall is low; all per-output bit logic and the
//   saturating lock-age counters update in the same cycle as the transfer.
//   A held result stalls the input only while the receiver asserts
//   out_stall; a result taken in a cycle frees the register for the next.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write only while idle. Index 0 enables over-voltage handling,
//   1 sets the over-voltage hold, 2 the thermal hold; others are dropped.
//   Reset (rst_n low, asynchronous) clears all output and lock state, the
//   age counters and the output valid flag, and restores the default holds.
// ---------------------------------------------------------------------------
module output_fault_protection_lock #(
    parameter int NUM_OUTPUTS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  mode,
    input  logic [ofpl_pkg::FIELD_W-1:0] status_bits,
    input  logic [2:0]                  pin_index,
    input  logic                        pin_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ofpl_pkg::FIELD_W-1:0] drive_bits,
    output logic [ofpl_pkg::FIELD_W-1:0] push_pull_bits,
    output logic [ofpl_pkg::FIELD_W-1:0] ov_lock_bits,
    output logic [ofpl_pkg::FIELD_W-1:0] thermal_lock_bits,
    output logic                        accepted,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [ofpl_pkg::CFG_W-1:0]  cfg_data
);

    import ofpl_pkg::*;

    localparam int VW = (NUM_OUTPUTS > FIELD_W) ? NUM_OUTPUTS : FIELD_W;

    logic                   ov_en_reg;
    logic [AGE_W-1:0]       ov_hold_reg;
    logic [AGE_W-1:0]       th_hold_reg;

    logic [NUM_OUTPUTS-1:0] drive_reg, drive_next;
    logic [NUM_OUTPUTS-1:0] drv_req_reg, drv_req_next;
    logic [NUM_OUTPUTS-1:0] pp_reg, pp_next;
    logic [NUM_OUTPUTS-1:0] pp_req_reg, pp_req_next;
    logic [NUM_OUTPUTS-1:0] ov_reg, ov_next;
    logic [NUM_OUTPUTS-1:0] th_reg, th_next;
    logic [AGE_W-1:0]       age_reg [NUM_OUTPUTS];
    logic [AGE_W-1:0]       age_next [NUM_OUTPUTS];

    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]     drive_out_reg, pp_out_reg, ov_out_reg, th_out_reg;
    logic                   acc_out_reg, acc_next;

    logic                   in_xfer;
    logic [VW-1:0]          flags_wide;
    logic [NUM_OUTPUTS-1:0] flags;
    logic [NUM_OUTPUTS-1:0] sel;
    logic                   in_range;
    logic                   locked;
    logic [VW-1:0]          drive_wide, pp_wide, ov_wide, th_wide;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_xfer   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    assign flags_wide = VW'(status_bits);
    assign flags      = flags_wide[NUM_OUTPUTS-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            sel[i] = ({29'd0, pin_index} == 32'(i));
        end
    end

    assign in_range = |sel;
    assign locked   = |(sel & (ov_reg | th_reg));

    always_comb
    begin
        drive_next   = drive_reg;
        drv_req_next = drv_req_reg;
        pp_next      = pp_reg;
        pp_req_next  = pp_req_reg;
        ov_next      = ov_reg;
        th_next      = th_reg;
        acc_next     = 1'b1;
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            age_next[i] = age_reg[i];
        end
        unique case (mode)
            MODE_TICK:
            begin
                for (int i = 0; i < NUM_OUTPUTS; i++)
                begin
                    if (age_reg[i] != AGE_MAX)
                    begin
                        age_next[i] = age_reg[i] + 1'b1;
                    end
                end
            end
            MODE_OV:
            begin
                if (ov_en_reg)
                begin
                    for (int i = 0; i < NUM_OUTPUTS; i++)
                    begin
                        if (flags[i] && !pp_reg[i])
                        begin
                            ov_next[i]  = 1'b1;
                            age_next[i] = '0;
                            if (!drive_reg[i] && !th_reg[i])
                            begin
                                drive_next[i] = 1'b1;
                            end
                        end
                        else if (ov_reg[i] && (age_reg[i] > ov_hold_reg))
                        begin
                            ov_next[i] = 1'b0;
                            if (!th_reg[i])
                            begin
                                drive_next[i] = drv_req_reg[i];
                            end
                        end
                    end
                end
            end
            MODE_THERMAL:
            begin
                for (int i = 0; i < NUM_OUTPUTS; i++)
                begin
                    if (flags[i])
                    begin
                        th_next[i]    = 1'b1;
                        pp_next[i]    = 1'b0;
                        drive_next[i] = 1'b0;
                        age_next[i]   = '0;
                    end
                    else if (th_reg[i] && (age_reg[i] > th_hold_reg))
                    begin
                        th_next[i]    = 1'b0;
                        pp_next[i]    = pp_req_reg[i];
                        drive_next[i] = drv_req_reg[i];
                    end
                end
            end
            MODE_DRIVE_WR:
            begin
                acc_next = in_range & ~locked;
                for (int i = 0; i < NUM_OUTPUTS; i++)
                begin
                    if (sel[i])
                    begin
                        drv_req_next[i] = pin_value;
                        if (!locked)
                        begin
                            drive_next[i] = pin_value;
                        end
                    end
                end
            end
            MODE_PP_WR:
            begin
                acc_next = in_range & ~locked;
                for (int i = 0; i < NUM_OUTPUTS; i++)
                begin
                    if (sel[i])
                    begin
                        pp_req_next[i] = pin_value;
                        if (!locked)
                        begin
                            pp_next[i] = pin_value;
                        end
                    end
                end
            end
            default:
            begin
                acc_next = 1'b1;
            end
        endcase
    end

    assign drive_wide = VW'(drive_next);
    assign pp_wide    = VW'(pp_next);
    assign ov_wide    = VW'(ov_next);
    assign th_wide    = VW'(th_next);

    assign out_valid_next = in_xfer | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_en_reg   <= 1'b0;
            ov_hold_reg <= OV_HOLD_RESET;
            th_hold_reg <= TH_HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OV_ENABLE: ov_en_reg   <= cfg_data[0];
                CFG_OV_HOLD:   ov_hold_reg <= cfg_data;
                CFG_TH_HOLD:   th_hold_reg <= cfg_data;
                default:       ov_en_reg   <= ov_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= '0;
            drv_req_reg <= '0;
            pp_reg      <= '0;
            pp_req_reg  <= '0;
            ov_reg      <= '0;
            th_reg      <= '0;
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (in_xfer)
        begin
            drive_reg   <= drive_next;
            drv_req_reg <= drv_req_next;
            pp_reg      <= pp_next;
            pp_req_reg  <= pp_req_next;
            ov_reg      <= ov_next;
            th_reg      <= th_next;
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            drive_out_reg <= drive_wide[FIELD_W-1:0];
            pp_out_reg    <= pp_wide[FIELD_W-1:0];
            ov_out_reg    <= ov_wide[FIELD_W-1:0];
            th_out_reg    <= th_wide[FIELD_W-1:0];
            acc_out_reg   <= acc_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign drive_bits        = drive_out_reg;
    assign push_pull_bits    = pp_out_reg;
    assign ov_lock_bits      = ov_out_reg;
    assign thermal_lock_bits = th_out_reg;
    assign accepted          = acc_out_reg;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no pending result");

    a_ov_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (mode == MODE_OV) && !ov_en_reg)
        |=> ((ov_reg == $past(ov_reg)) && (drive_reg == $past(drive_reg))))
        else $error("over-voltage sample changed state while disabled");

    a_thermal_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (mode == MODE_THERMAL))
        |=> (((th_reg & $past(flags)) == $past(flags))
             && ((drive_reg & $past(flags)) == '0)))
        else $error("thermal flag did not lock and clear its output");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (out_valid_reg && (acc_out_reg == $past(acc_next))))
        else $error("result register missed a transfer");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: output fault protection lock
// Drives mode, status and user-write items through the valid/stall input
// channel in random bursts, while the receiver stalls on its own pattern.
// A built-in lock model tracks drive, push-pull, lock bits and lock ages,
// and every result transfer is checked against the oldest prediction.
// Configuration is rewritten between phases, from a zero hold to long holds.
// ---------------------------------------------------------------------------
module testbench;
    import ofpl_pkg::*;

    localparam int NUM_OUT = 8;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam int LONG_TICKS = 160;

    typedef struct packed {
        logic [2:0]         mode;
        logic [FIELD_W-1:0] status;
        logic [2:0]         pin;
        logic               value;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] drive;
        logic [FIELD_W-1:0] push_pull;
        logic [FIELD_W-1:0] ov_lock;
        logic [FIELD_W-1:0] th_lock;
        logic               accepted;
    } lock_status_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [2:0]         mode        = '0;
    logic [FIELD_W-1:0] status_bits = '0;
    logic [2:0]         pin_index   = '0;
    logic               pin_value   = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [FIELD_W-1:0] drive_bits;
    logic [FIELD_W-1:0] push_pull_bits;
    logic [FIELD_W-1:0] ov_lock_bits;
    logic [FIELD_W-1:0] thermal_lock_bits;
    logic               accepted;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index   = '0;
    logic [CFG_W-1:0]   cfg_data    = '0;

    output_fault_protection_lock #(
        .NUM_OUTPUTS(NUM_OUT)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .status_bits      (status_bits),
        .pin_index        (pin_index),
        .pin_value        (pin_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_bits       (drive_bits),
        .push_pull_bits   (push_pull_bits),
        .ov_lock_bits     (ov_lock_bits),
        .thermal_lock_bits(thermal_lock_bits),
        .accepted         (accepted),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // lock model state
    logic               prot_enable;
    logic [AGE_W-1:0]   ov_hold;
    logic [AGE_W-1:0]   th_hold;
    logic [NUM_OUT-1:0] drive_q;
    logic [NUM_OUT-1:0] drive_req;
    logic [NUM_OUT-1:0] pp_q;
    logic [NUM_OUT-1:0] pp_req;
    logic [NUM_OUT-1:0] ov_lock_q;
    logic [NUM_OUT-1:0] th_lock_q;
    logic [AGE_W-1:0]   lock_age_q [NUM_OUT];

    item_t        pending_items[$];
    lock_status_t expected_status[$];
    int unsigned  items_queued   = 0;
    int unsigned  results_seen   = 0;
    int unsigned  error_count    = 0;
    int unsigned  settings_count = 0;
    logic         taken          = 1'b0;
    int unsigned  burst_left     = 1;
    int unsigned  gap_left       = 0;
    int unsigned  stall_span     = 0;
    logic [31:0]  stall_bits     = '0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic reset_lock_model();
        prot_enable = 1'b0;
        ov_hold     = OV_HOLD_RESET;
        th_hold     = TH_HOLD_RESET;
        drive_q     = '0;
        drive_req   = '0;
        pp_q        = '0;
        pp_req      = '0;
        ov_lock_q   = '0;
        th_lock_q   = '0;
        for (int i = 0; i < NUM_OUT; i++)
            lock_age_q[i] = '0;
    endtask

    task automatic apply_config(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_OV_ENABLE: prot_enable = data[0];
            CFG_OV_HOLD:   ov_hold     = data;
            CFG_TH_HOLD:   th_hold     = data;
            default: ;
        endcase
    endtask

    function automatic lock_status_t advance_lock_model(item_t it);
        lock_status_t r;
        logic         locked;
        r.accepted = 1'b1;
        case (it.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < NUM_OUT; i++)
                    if (lock_age_q[i] != AGE_MAX)
                        lock_age_q[i] = lock_age_q[i] + 1'b1;
            end
            MODE_OV:
            begin
                if (prot_enable)
                begin
                    for (int i = 0; i < NUM_OUT; i++)
                    begin
                        if (it.status[i] && !pp_q[i])
                        begin
                            ov_lock_q[i] = 1'b1;
                            if (!drive_q[i] && !th_lock_q[i])
                                drive_q[i] = 1'b1;
                            lock_age_q[i] = '0;
                        end
                        else if (ov_lock_q[i] && lock_age_q[i] > ov_hold)
                        begin
                            if (!th_lock_q[i])
                                drive_q[i] = drive_req[i];
                            ov_lock_q[i] = 1'b0;
                        end
                    end
                end
            end
            MODE_THERMAL:
            begin
                for (int i = 0; i < NUM_OUT; i++)
                begin
                    if (it.status[i])
                    begin
                        th_lock_q[i]  = 1'b1;
                        pp_q[i]       = 1'b0;
                        drive_q[i]    = 1'b0;
                        lock_age_q[i] = '0;
                    end
                    else if (th_lock_q[i] && lock_age_q[i] > th_hold)
                    begin
                        pp_q[i]      = pp_req[i];
                        drive_q[i]   = drive_req[i];
                        th_lock_q[i] = 1'b0;
                    end
                end
            end
            MODE_DRIVE_WR, MODE_PP_WR:
            begin
                if (int'(it.pin) >= NUM_OUT)
                    r.accepted = 1'b0;
                else
                begin
                    locked = ov_lock_q[it.pin] || th_lock_q[it.pin];
                    if (it.mode == MODE_DRIVE_WR)
                    begin
                        drive_req[it.pin] = it.value;
                        if (!locked)
                            drive_q[it.pin] = it.value;
                    end
                    else
                    begin
                        pp_req[it.pin] = it.value;
                        if (!locked)
                            pp_q[it.pin] = it.value;
                    end
                    r.accepted = !locked;
                end
            end
            default: ;
        endcase
        r.drive     = drive_q;
        r.push_pull = pp_q;
        r.ov_lock   = ov_lock_q;
        r.th_lock   = th_lock_q;
        return r;
    endfunction

    // input side: bursts with random gaps, payload held while stalled
    always @(negedge clk)
    begin : item_driver
        item_t nxt;
        logic  drive_valid;
        if (!in_valid || taken)
        begin
            taken = 1'b0;
            drive_valid = 1'b0;
            if (gap_left != 0)
                gap_left--;
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                drive_valid = 1'b1;
                mode        <= nxt.mode;
                status_bits <= nxt.status;
                pin_index   <= nxt.pin;
                pin_value   <= nxt.value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left--;
            end
            in_valid <= drive_valid;
        end
    end

    // output side: rotating random stall pattern, reshuffled when its span runs out
    always @(negedge clk)
    begin : stall_driver
        if (stall_span == 0)
        begin
            stall_span = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0:       stall_bits = '0;
                1:       stall_bits = $urandom;
                2:       stall_bits = $urandom & $urandom;
                default: stall_bits = $urandom | $urandom;
            endcase
        end
        stall_span--;
        out_stall  <= stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[31:1]};
    end

    always @(posedge clk)
    begin : monitor
        lock_status_t got;
        lock_status_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(
                    advance_lock_model('{mode, status_bits, pin_index, pin_value}));
                taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                got = '{drive_bits, push_pull_bits, ov_lock_bits, thermal_lock_bits, accepted};
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result transfer with no prediction pending", $realtime);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"%0t: mismatch drive %h/%h pp %h/%h ov %h/%h th %h/%h ",
                                      "acc %b/%b (expected/actual)"}, $realtime,
                                     want.drive, got.drive, want.push_pull, got.push_pull,
                                     want.ov_lock, got.ov_lock, want.th_lock, got.th_lock,
                                     want.accepted, got.accepted);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic en, input logic [CFG_W-1:0] ovh,
                             input logic [CFG_W-1:0] thh);
        write_reg(CFG_OV_ENABLE, {{(CFG_W-1){1'b0}}, en});
        write_reg(CFG_OV_HOLD, ovh);
        write_reg(CFG_TH_HOLD, thh);
        settings_count++;
    endtask

    task automatic queue_item(input item_t it);
        @(posedge clk);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (results_seen != items_queued);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] fault_flags();
        case ($urandom_range(0, 4))
            0:       return FIELD_W'(1) << $urandom_range(0, NUM_OUT - 1);
            1:       return FIELD_W'($urandom & $urandom);
            2:       return FIELD_W'($urandom);
            3:       return '1;
            default: return '0;
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick      = $urandom_range(0, 99);
        it.status = FIELD_W'($urandom);
        it.pin    = 3'($urandom);
        it.value  = 1'($urandom);
        if (pick < 30)
            it.mode = MODE_TICK;
        else if (pick < 45)
            it.mode = MODE_OV;
        else if (pick < 57)
            it.mode = MODE_THERMAL;
        else if (pick < 75)
            it.mode = MODE_DRIVE_WR;
        else if (pick < 93)
            it.mode = MODE_PP_WR;
        else
            it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return it;
    endfunction

    function automatic item_t filler_item();
        item_t it;
        int    pick;
        it   = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.mode = MODE_TICK;
        else if (pick < 90)
            it.mode = ($urandom_range(0, 1) != 0) ? MODE_DRIVE_WR : MODE_PP_WR;
        return it;
    endfunction

    // fault sample, ticks and writes around the hold time, then a release sample
    task automatic queue_episode(input int span);
        logic [2:0] kind;
        int         n;
        kind = ($urandom_range(0, 2) != 0) ? MODE_OV : MODE_THERMAL;
        queue_item('{kind, fault_flags(), 3'($urandom), 1'($urandom)});
        n = $urandom_range(0, span + 4);
        repeat (n) queue_item(filler_item());
        if ($urandom_range(0, 3) == 0)
            kind = (kind == MODE_OV) ? MODE_THERMAL : MODE_OV;
        queue_item('{kind, ($urandom_range(0, 1) != 0) ? '0 : fault_flags(),
                     3'($urandom), 1'($urandom)});
    endtask

    task automatic run_phase(input logic en, input logic [CFG_W-1:0] ovh,
                             input logic [CFG_W-1:0] thh, input int count);
        int unsigned target;
        int          span;
        configure(en, ovh, thh);
        span = int'((ovh > thh) ? ovh : thh);
        if (span > 10)
            span = 10;
        target = items_queued + count;
        while (items_queued < target)
        begin
            if ($urandom_range(0, 4) != 0)
                queue_episode(span);
            else
                queue_item(random_item());
        end
        drain();
    endtask

    initial
    begin
        reset_lock_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings, protection off
        queue_item('{MODE_OV,        8'hFF, 3'd0, 1'b0});
        queue_item('{MODE_DRIVE_WR,  8'h00, 3'd0, 1'b1});
        queue_item('{MODE_DRIVE_WR,  8'hFF, 3'd7, 1'b1});
        queue_item('{MODE_PP_WR,     8'h00, 3'd3, 1'b1});
        queue_item('{MODE_THERMAL,   8'h81, 3'd0, 1'b0});
        queue_item('{MODE_DRIVE_WR,  8'h00, 3'd0, 1'b0});
        queue_item('{MODE_PP_WR,     8'h00, 3'd7, 1'b1});
        queue_item('{MODE_SPARE_LO,  8'hA5, 3'd5, 1'b1});
        queue_item('{MODE_SPARE_MID, 8'h5A, 3'd2, 1'b0});
        queue_item('{MODE_SPARE_HI,  8'hFF, 3'd7, 1'b1});
        queue_item('{MODE_TICK,      8'hFF, 3'd7, 1'b1});
        queue_item('{MODE_THERMAL,   8'h00, 3'd0, 1'b0});
        drain();

        // protection on, zero holds
        configure(1'b1, '0, '0);
        queue_item('{MODE_PP_WR,    8'h00, 3'd1, 1'b1});
        queue_item('{MODE_OV,       8'hFF, 3'd0, 1'b0});
        queue_item('{MODE_TICK,     8'h00, 3'd0, 1'b0});
        queue_item('{MODE_OV,       8'h00, 3'd0, 1'b0});
        queue_item('{MODE_THERMAL,  8'h00, 3'd0, 1'b0});
        queue_item('{MODE_THERMAL,  8'hFF, 3'd0, 1'b0});
        queue_item('{MODE_DRIVE_WR, 8'h00, 3'd2, 1'b1});
        queue_item('{MODE_OV,       8'h0F, 3'd0, 1'b0});
        queue_item('{MODE_TICK,     8'h00, 3'd0, 1'b0});
        queue_item('{MODE_THERMAL,  8'h00, 3'd0, 1'b0});
        queue_item('{MODE_OV,       8'h00, 3'd0, 1'b0});
        queue_item('{MODE_TICK,     8'h00, 3'd0, 1'b0});
        drain();

        run_phase(1'b1, 16'd0, 16'd0, 300);
        run_phase(1'b1, 16'd3, 16'd5, 300);
        run_phase(1'b0, 16'd2, 16'd1, 250);
        run_phase(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 300);
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 200);
        run_phase(1'b1, 16'($urandom), 16'd4, 250);

        // long lock ages: over-voltage never releases, thermal does
        configure(1'b1, 16'hFFFF, 16'd100);
        queue_item('{MODE_PP_WR,    8'h00, 3'd6, 1'b0});
        queue_item('{MODE_THERMAL,  8'h0F, 3'd0, 1'b0});
        queue_item('{MODE_OV,       8'hF0, 3'd0, 1'b0});
        for (int i = 0; i < LONG_TICKS; i++)
        begin
            if (i % 256 == 0)
                @(posedge clk);
            pending_items.push_back('{MODE_TICK, FIELD_W'($urandom), 3'($urandom),
                                      1'($urandom)});
            items_queued++;
        end
        queue_item('{MODE_OV,       8'h00, 3'd0, 1'b0});
        queue_item('{MODE_DRIVE_WR, 8'h00, 3'd5, 1'b1});
        queue_item('{MODE_THERMAL,  8'h00, 3'd0, 1'b0});
        queue_item('{MODE_DRIVE_WR, 8'h00, 3'd1, 1'b1});
        drain();

        if (expected_status.size() != 0)
            error_count += expected_status.size();
        $display("Checked %0d results from %0d items across %0d configuration settings,",
                 results_seen, items_queued, settings_count);
        $display("including zero holds, disabled protection and long lock ages.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/ofpl_pkg.sv
rtl/output_fault_protection_lock.sv
tb/sv/testbench.sv
